@@ hdl/pca_pkg.sv @@
`default_nettype none
package pca_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_out;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
  } pix_out_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic [2:0][23:0] s;      // byte * gain
    logic [1:0]       sel;    // index of the brightest channel
    logic             over;   // brightest channel above one
    logic [7:0]       alpha;
    logic             last;
  } front_word_t;

  localparam logic [2:0] REG_GAIN       = 3'd0;
  localparam logic [2:0] REG_CONTRAST   = 3'd1;
  localparam logic [2:0] REG_SATURATION = 3'd2;
  localparam logic [2:0] REG_MONO       = 3'd3;
  localparam logic [2:0] REG_INVERT     = 3'd4;

  localparam logic [23:0] OVER_LIMIT = 24'd1044480; // 255 * 4096
  localparam logic [29:0] SUM_MAX    = 30'h3FFF_FFFF;
  localparam logic [22:0] COUNT_MAX  = 23'h7F_FFFF;

endpackage
`default_nettype wire

@@ hdl/pca_front.sv @@
`default_nettype none
module pca_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  [15:0]           gain,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  pca_pkg::pix_in_t      in_word,
  output logic                  fw_valid,
  input  wire                   fw_ready,
  output pca_pkg::front_word_t  fw
);
  logic [23:0] sr, sg, sb;
  pca_pkg::front_word_t w;

  always_comb begin
    sr = 24'(in_word.red_in) * 24'(gain);
    sg = 24'(in_word.green_in) * 24'(gain);
    sb = 24'(in_word.blue_in) * 24'(gain);
    w.s[0] = sr;
    w.s[1] = sg;
    w.s[2] = sb;
    w.alpha = in_word.alpha_in;
    w.last = in_word.last_pixel;
    if (sr >= sg && sr >= sb) w.sel = 2'd0;
    else if (sg >= sb) w.sel = 2'd1;
    else w.sel = 2'd2;
    w.over = (sr > pca_pkg::OVER_LIMIT) || (sg > pca_pkg::OVER_LIMIT) ||
             (sb > pca_pkg::OVER_LIMIT);
  end

  assign in_ready = !fw_valid || fw_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (in_ready) begin
      fw_valid <= in_valid;
    end
    if (in_ready && in_valid) fw <= w;
  end
endmodule
`default_nettype wire

@@ hdl/pca_queue.sv @@
`default_nettype none
module pca_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr_valid,
  output logic                 wr_ready,
  input  pca_pkg::front_word_t wr_data,
  output logic                 rd_valid,
  input  wire                  rd_ready,
  output pca_pkg::front_word_t rd_data
);
  pca_pkg::front_word_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  logic wr, rd;

  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      fill <= fill + 2'(wr) - 2'(rd);
    end
    if (wr) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

@@ hdl/pca_back.sv @@
`default_nettype none
module pca_back #(
  parameter int MAX_SIDE = 2048
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  [15:0]          contrast,
  input  wire  [15:0]          saturation,
  input  wire                  mono_enable,
  input  wire                  invert_enable,
  input  wire                  q_valid,
  output logic                 q_ready,
  input  pca_pkg::front_word_t q,
  output logic                 out_valid,
  input  wire                  out_ready,
  output pca_pkg::pix_out_t    out_word
);
  localparam longint LimRaw = longint'(MAX_SIDE) * longint'(MAX_SIDE);
  localparam logic [22:0] CountLim =
    (LimRaw < 64'h7F_FFFF) ? 23'(LimRaw) : pca_pkg::COUNT_MAX;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_CON, S_CLAMP, S_LUMA, S_SAT, S_BYTE, S_ACC, S_AVG, S_FIN
  } state_t;

  state_t state;
  pca_pkg::front_word_t cur;
  logic [1:0] k;
  // shared restoring divider
  logic [40:0] num;
  logic [33:0] rem;
  logic [29:0] den;
  logic [5:0]  dcnt;
  logic [2:0][16:0] tv;
  logic [2:0][16:0] cv;
  logic signed [41:0] prod;
  logic [16:0] lum;
  logic [35:0] lacc;
  logic [2:0][7:0] px;
  logic [2:0][7:0] av;
  logic [2:0][29:0] sums;
  logic [22:0] count;
  logic [34:0] rem_sh;
  logic [49:0] recip;

  assign q_ready = state == S_IDLE;
  assign rem_sh = {rem, num[40]};
  assign lum = lacc[32:16];
  // 16*s/255 as a reciprocal multiply, exact for 16*s below 2^24
  assign recip = 50'({cur.s[k], 4'd0}) * 50'd16843010;

  function automatic logic [7:0] post(input logic [2:0][7:0] v, input int i,
                                      input logic mono, input logic inv);
    logic [9:0] sm;
    logic [19:0] q3;
    logic [7:0] r;
    sm = 10'(v[0]) + 10'(v[1]) + 10'(v[2]);
    q3 = 20'(sm) * 20'd683;   // sum / 3 by reciprocal
    r = mono ? q3[18:11] : v[i];
    return inv ? 8'd255 - r : r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sums <= '0;
      count <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cur <= q;
            k <= 2'd0;
            state <= S_NORM;
            dcnt <= '0;
          end
        end
        S_NORM: begin
          // per channel: s*65536/m by bit-serial division, or s*16/255
          if (dcnt == 6'd0 && !cur.over) begin
            tv[k] <= recip[48:32];
            if (k == 2'd2) begin
              k <= 2'd0;
              state <= S_CON;
            end else k <= k + 2'd1;
          end else if (dcnt == 6'd0) begin
            num <= {1'b0, cur.s[k], 16'd0};
            den <= {6'd0, cur.s[cur.sel]};
            rem <= '0;
            dcnt <= 6'd1;
          end else if (dcnt <= 6'd41) begin
            if ({1'b0, rem_sh} >= {6'd0, den}) begin
              rem <= 34'(rem_sh - 35'(den));
              num <= {num[39:0], 1'b1};
            end else begin
              rem <= rem_sh[33:0];
              num <= {num[39:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
          end else begin
            tv[k] <= num[16:0];
            dcnt <= '0;
            if (k == 2'd2) begin
              k <= 2'd0;
              state <= S_CON;
            end else k <= k + 2'd1;
          end
        end
        S_CON: begin
          prod <= $signed({25'd0, tv[k]}) * $signed({26'd0, contrast}) +
                  42'sd134217728 - $signed({26'd0, contrast}) * 42'sd32768;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (prod < 0) cv[k] <= '0;
          else if (prod[41:12] > 30'd65536) cv[k] <= 17'd65536;
          else cv[k] <= prod[28:12];
          if (k == 2'd2) begin
            k <= 2'd0;
            lacc <= '0;
            state <= S_LUMA;
          end else begin
            k <= k + 2'd1;
            state <= S_CON;
          end
        end
        S_LUMA: begin
          unique case (k)
            2'd0: lacc <= lacc + 36'(cv[0]) * 36'd13926;
            2'd1: lacc <= lacc + 36'(cv[1]) * 36'd46884;
            default: lacc <= lacc + 36'(cv[2]) * 36'd4725;
          endcase
          if (k == 2'd2) begin
            k <= 2'd0;
            state <= S_SAT;
          end else k <= k + 2'd1;
        end
        S_SAT: begin
          prod <= $signed({25'd0, lum}) * 42'sd4096 +
                  $signed({26'd0, saturation}) *
                  ($signed({25'd0, cv[k]}) - $signed({25'd0, lum}));
          state <= S_BYTE;
        end
        S_BYTE: begin
          // v*255/65536, clamp
          if (prod < 0) px[k] <= 8'd0;
          else if (prod[41:12] * 30'd255 >= 30'(255 * 65536)) px[k] <= 8'd255;
          else px[k] <= 8'((prod[41:12] * 30'd255) >> 16);
          if (k == 2'd2) begin
            k <= 2'd0;
            state <= S_ACC;
          end else begin
            k <= k + 2'd1;
            state <= S_SAT;
          end
        end
        S_ACC: begin
          for (int i = 0; i < 3; i++) begin
            if ({1'b0, sums[i]} + 31'(px[i]) > {1'b0, pca_pkg::SUM_MAX})
              sums[i] <= pca_pkg::SUM_MAX;
            else sums[i] <= sums[i] + 30'(px[i]);
          end
          if (count < CountLim) count <= count + 23'd1;
          av <= '0;
          k <= 2'd0;
          dcnt <= '0;
          state <= cur.last ? S_AVG : S_FIN;
        end
        S_AVG: begin
          // sum/count per channel, same shared divider
          if (dcnt == 6'd0) begin
            num <= {11'd0, sums[k]};
            den <= {7'd0, count};
            rem <= '0;
            dcnt <= 6'd1;
          end else if (dcnt <= 6'd41) begin
            if ({1'b0, rem_sh} >= {6'd0, den}) begin
              rem <= 34'(rem_sh - 35'(den));
              num <= {num[39:0], 1'b1};
            end else begin
              rem <= rem_sh[33:0];
              num <= {num[39:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
          end else begin
            av[k] <= (count == '0) ? 8'd0 : ((num[29:8] != '0) ? 8'd255 : num[7:0]);
            dcnt <= '0;
            if (k == 2'd2) begin
              sums <= '0;
              count <= '0;
              state <= S_FIN;
            end else k <= k + 2'd1;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_word.red_out   <= post(px, 0, mono_enable, invert_enable);
            out_word.green_out <= post(px, 1, mono_enable, invert_enable);
            out_word.blue_out  <= post(px, 2, mono_enable, invert_enable);
            out_word.alpha_out <= cur.alpha;
            out_word.last_out  <= cur.last;
            out_word.avg_red   <= cur.last ? post(av, 0, mono_enable, invert_enable) : 8'd0;
            out_word.avg_green <= cur.last ? post(av, 1, mono_enable, invert_enable) : 8'd0;
            out_word.avg_blue  <= cur.last ? post(av, 2, mono_enable, invert_enable) : 8'd0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/pixel_color_adjust_top.sv @@
`default_nettype none
// Pixel colour adjust: gain with hue-preserving normalisation, contrast about
// mid grey, saturation mix with the luminance grey, optional mono and invert,
// alpha untouched; image average colour given with the last pixel. The front
// multiplies by gain, finds the brightest channel combinationally and hands a
// registered word to a two-entry queue; the back runs one word at a time.
// When gain lifts the brightest channel above one, the three divisions by
// that channel go through a shared 41-step bit-serial divider; a last pixel
// uses the same divider for the three averages. Output stalls hold the back in
// its last state while the queue lets the front keep accepting until it
// fills. The user must see that configuration is written only while idle;
// the block does not enforce it. Indexes beyond the register list are ignored.
module pixel_color_adjust_top #(
  parameter int MAX_SIDE = 2048
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  pca_pkg::pix_in_t   in_word,
  output logic               out_valid,
  input  wire                out_ready,
  output pca_pkg::pix_out_t  out_word,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [15:0]        cfg_data
);
  logic [15:0] gain, contrast, saturation;
  logic mono_enable, invert_enable;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 16'd4096;
      contrast <= 16'd4096;
      saturation <= 16'd4096;
      mono_enable <= 1'b0;
      invert_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pca_pkg::REG_GAIN:       gain <= cfg_data;
        pca_pkg::REG_CONTRAST:   contrast <= cfg_data;
        pca_pkg::REG_SATURATION: saturation <= cfg_data;
        pca_pkg::REG_MONO:       mono_enable <= cfg_data[0];
        pca_pkg::REG_INVERT:     invert_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic fw_valid, fw_ready, q_valid, q_ready;
  pca_pkg::front_word_t fw, q;

  pca_front u_front (
    .clk, .rst, .gain, .in_valid, .in_ready, .in_word,
    .fw_valid, .fw_ready, .fw
  );

  pca_queue u_queue (
    .clk, .rst, .wr_valid(fw_valid), .wr_ready(fw_ready), .wr_data(fw),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q)
  );

  pca_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk, .rst, .contrast, .saturation, .mono_enable, .invert_enable,
    .q_valid, .q_ready, .q, .out_valid, .out_ready, .out_word
  );

  // averages only carry data on a last word
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.last_out |-> out_word.avg_red == 8'd0 &&
    out_word.avg_green == 8'd0 && out_word.avg_blue == 8'd0)
    else $error("averages set on a non-last word");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // mono output gives equal channels
  a_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && mono_enable && $stable(mono_enable) |->
    out_word.red_out == out_word.green_out)
    else $error("mono channels differ");
endmodule
`default_nettype wire
